@@ sv/fpba_pkg.sv @@
package fpba_pkg;

	localparam int FUNC_W = 2;
	localparam int IDX_OUT_W = 4;
	localparam int SIZE_W = 16;
	localparam int SUM_W = 32;
	localparam int MODE_W = 2;
	localparam int BCNT_W = 5;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 5;

	localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	localparam logic [MODE_W-1:0] MODE_BEST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 4'd1;

	localparam logic [MODE_W-1:0] FIT_MODE_RST = MODE_FIRST;
	localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

@@ sv/fpba_if.sv @@
interface fpba_cmd_if
	import fpba_pkg::*;
;
	logic valid;
	logic ready;
	logic [FUNC_W-1:0] func;
	logic [IDX_OUT_W-1:0] block_index;
	logic [SIZE_W-1:0] size;

	modport source (output valid, func, block_index, size, input ready);
	modport sink (input valid, func, block_index, size, output ready);
endinterface

interface fpba_rsp_if
	import fpba_pkg::*;
;
	logic valid;
	logic ready;
	logic granted;
	logic [IDX_OUT_W-1:0] chosen_block;
	logic [SIZE_W-1:0] leftover;
	logic [SUM_W-1:0] internal_total;
	logic [SUM_W-1:0] external_total;

	modport source (output valid, granted, chosen_block, leftover, internal_total,
		external_total, input ready);
	modport sink (input valid, granted, chosen_block, leftover, internal_total,
		external_total, output ready);
endinterface

interface fpba_cfg_if
	import fpba_pkg::*;
;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/fpba_cell.sv @@
module fpba_cell
	import fpba_pkg::*;
#(
	parameter int J = 0,
	parameter int SIZE_BITS = 16,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5,
	parameter type tok_t = logic,
	parameter type upd_t = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  tok_t tok_in,
	output tok_t tok_out,
	input  upd_t upd
);

	logic [SIZE_BITS-1:0] size_q;
	logic used_q;
	logic valid_q;
	tok_t tok_q;
	tok_t tok_nxt;
	logic active;
	logic fits;
	logic take;
	logic hit;

	assign active = tok_in.n > CNT_W'(J);
	assign fits = active && (size_q >= tok_in.req);
	assign hit = upd.idx == IDX_W'(J);

	always_comb begin
		if (tok_in.mode == MODE_FIRST) begin
			take = fits && !tok_in.found;
		end else begin
			take = fits && !used_q && (!tok_in.found ||
				(tok_in.mode == MODE_BEST && size_q < tok_in.pick_size) ||
				(tok_in.mode == MODE_WORST && size_q > tok_in.pick_size));
		end
		tok_nxt = tok_in;
		if (take) begin
			tok_nxt.found = 1'b1;
			tok_nxt.pick = IDX_W'(J);
			tok_nxt.pick_size = size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			used_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
			if (upd.clr_used) begin
				used_q <= 1'b0;
			end else if (upd.set_used && hit) begin
				used_q <= 1'b1;
			end
		end
	end

	// block sizes are undefined until loaded
	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		if (upd.wr && hit) begin
			size_q <= upd.wdata;
		end
	end

	always_comb begin
		tok_out = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

@@ sv/fit_policy_block_allocator_core.sv @@
// Channel  Role    Moves                                           Handshake
// cmd      sink    func, block_index, size                        valid/ready
// rsp      source  granted, chosen_block, leftover, totals        valid/ready
// cfg      sink    index, data (fit_mode, block_count)            valid/ready, ready=1
//
// Load, clear and unused func: result is registered on the accepting edge.
// Allocate: a search token walks the cell row one cell per cycle; its result is captured
// as it leaves the last cell and goes to rsp once the output is free; then cmd reopens.
// One item at a time; cmd is held off while a result waits and is not being taken.
// arst_n clears control, used marks and totals; block sizes stay undefined.
module fit_policy_block_allocator_core
	import fpba_pkg::*;
#(
	parameter int BLOCKS = 16,
	parameter int SIZE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	fpba_cmd_if.sink cmd,
	fpba_rsp_if.source rsp,
	fpba_cfg_if.sink cfg
);

	localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int CNT_W = $clog2(BLOCKS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	typedef struct packed {
		logic valid;
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0] n;
		logic [SIZE_BITS-1:0] req;
		logic found;
		logic [IDX_W-1:0] pick;
		logic [SIZE_BITS-1:0] pick_size;
	} tok_t;

	typedef struct packed {
		logic wr;
		logic [IDX_W-1:0] idx;
		logic [SIZE_BITS-1:0] wdata;
		logic set_used;
		logic clr_used;
	} upd_t;

	logic [1:0] state_q;
	logic [MODE_W-1:0] fit_mode_q;
	logic [BCNT_W-1:0] block_count_q;
	logic [SUM_W-1:0] int_sum_q;
	logic [SUM_W-1:0] ext_sum_q;

	logic out_v_q;
	logic granted_q;
	logic [IDX_OUT_W-1:0] chosen_q;
	logic [SIZE_W-1:0] leftover_q;
	logic [SUM_W-1:0] int_tot_q;
	logic [SUM_W-1:0] ext_tot_q;

	logic res_found_q;
	logic [IDX_W-1:0] res_pick_q;
	logic [SIZE_BITS-1:0] res_left_q;
	logic [SIZE_BITS-1:0] res_req_q;
	logic [MODE_W-1:0] res_mode_q;

	tok_t tok [BLOCKS+1];
	upd_t upd;
	logic [BLOCKS-1:0] chain_vld;
	logic [IDX_W-1:0] wrap_lut [2**IDX_OUT_W];

	logic out_free;
	logic acc;
	logic finish;
	logic [SIZE_BITS-1:0] cmd_req;
	logic [MODE_W-1:0] mode_eff;
	logic [CNT_W-1:0] n_eff;
	logic [SUM_W:0] int_add;
	logic [SUM_W:0] ext_add;
	logic [SUM_W-1:0] int_new;
	logic [SUM_W-1:0] ext_new;

	assign out_free = !out_v_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign acc = cmd.valid && cmd.ready;
	assign finish = (state_q == ST_DONE) && out_free;
	assign cfg.ready = 1'b1;
	assign cmd_req = SIZE_BITS'(cmd.size);

	assign mode_eff = (fit_mode_q == MODE_WORST || fit_mode_q == MODE_BEST) ?
		fit_mode_q : MODE_FIRST;
	assign n_eff = (int'(block_count_q) > BLOCKS) ? CNT_W'(BLOCKS) : CNT_W'(block_count_q);

	always_comb begin
		for (int k = 0; k < 2**IDX_OUT_W; k++) begin
			wrap_lut[k] = IDX_W'(k % BLOCKS);
		end
	end

	assign tok[0].valid = acc && (cmd.func == FUNC_ALLOC);
	assign tok[0].mode = mode_eff;
	assign tok[0].n = n_eff;
	assign tok[0].req = cmd_req;
	assign tok[0].found = 1'b0;
	assign tok[0].pick = '0;
	assign tok[0].pick_size = '0;

	genvar g;
	generate
		for (g = 0; g < BLOCKS; g++) begin : g_cell
			fpba_cell #(
				.J(g),
				.SIZE_BITS(SIZE_BITS),
				.IDX_W(IDX_W),
				.CNT_W(CNT_W),
				.tok_t(tok_t),
				.upd_t(upd_t)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.tok_in(tok[g]),
				.tok_out(tok[g+1]),
				.upd(upd)
			);
			assign chain_vld[g] = tok[g+1].valid;
		end
	endgenerate

	// table writes: loads and used-mark clears at acceptance, allocation writeback when the result leaves
	always_comb begin
		upd = '0;
		if (acc && cmd.func == FUNC_LOAD) begin
			upd.wr = 1'b1;
			upd.idx = wrap_lut[cmd.block_index];
			upd.wdata = cmd_req;
		end else if (acc && cmd.func == FUNC_CLEAR) begin
			upd.clr_used = 1'b1;
		end else if (finish && res_found_q) begin
			upd.wr = 1'b1;
			upd.idx = res_pick_q;
			upd.wdata = res_left_q;
			upd.set_used = res_mode_q != MODE_FIRST;
		end
	end

	assign int_add = {1'b0, int_sum_q} + (SUM_W+1)'(res_left_q);
	assign ext_add = {1'b0, ext_sum_q} + (SUM_W+1)'(res_req_q);
	assign int_new = (res_found_q && !int_add[SUM_W]) ? int_add[SUM_W-1:0] :
		(res_found_q ? SUM_MAX : int_sum_q);
	assign ext_new = (!res_found_q && !ext_add[SUM_W]) ? ext_add[SUM_W-1:0] :
		(!res_found_q ? SUM_MAX : ext_sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fit_mode_q <= FIT_MODE_RST;
			block_count_q <= BLOCK_COUNT_RST;
			int_sum_q <= '0;
			ext_sum_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_FIT_MODE: fit_mode_q <= cfg.data[MODE_W-1:0];
					REG_BLOCK_COUNT: block_count_q <= cfg.data[BCNT_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc && cmd.func == FUNC_ALLOC) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok[BLOCKS].valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (acc && cmd.func == FUNC_CLEAR) begin
				int_sum_q <= '0;
				ext_sum_q <= '0;
			end else if (finish) begin
				int_sum_q <= int_new;
				ext_sum_q <= ext_new;
			end

			if ((acc && cmd.func != FUNC_ALLOC) || finish) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && tok[BLOCKS].valid) begin
			res_found_q <= tok[BLOCKS].found;
			res_pick_q <= tok[BLOCKS].pick;
			res_left_q <= tok[BLOCKS].pick_size - tok[BLOCKS].req;
			res_req_q <= tok[BLOCKS].req;
			res_mode_q <= tok[BLOCKS].mode;
		end

		if (acc && cmd.func != FUNC_ALLOC) begin
			granted_q <= 1'b0;
			chosen_q <= '0;
			leftover_q <= '0;
			int_tot_q <= (cmd.func == FUNC_CLEAR) ? '0 : int_sum_q;
			ext_tot_q <= (cmd.func == FUNC_CLEAR) ? '0 : ext_sum_q;
		end else if (finish) begin
			granted_q <= res_found_q;
			chosen_q <= res_found_q ? IDX_OUT_W'(res_pick_q) : '0;
			leftover_q <= res_found_q ? SIZE_W'(res_left_q) : '0;
			int_tot_q <= int_new;
			ext_tot_q <= ext_new;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.granted = granted_q;
	assign rsp.chosen_block = chosen_q;
	assign rsp.leftover = leftover_q;
	assign rsp.internal_total = int_tot_q;
	assign rsp.external_total = ext_tot_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(chain_vld) <= 1)
		else $error("more than one search token in the cell row");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_vld != '0 |-> state_q == ST_SCAN)
		else $error("search token present outside scan");

	a_scan_entry: assert property (@(posedge clk) disable iff (!arst_n)
		tok[0].valid |=> state_q == ST_SCAN && chain_vld[0])
		else $error("allocate transaction did not start a scan");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_free |=> state_q == ST_DONE && $stable(res_left_q))
		else $error("finished scan result lost while output busy");

endmodule
